[rtl/core/tgb_pkg.sv]
// Package with the field widths, register indexes, reset values and codes of the tap controller.
package tgb_pkg;

  localparam int TIMER_BITS_DEF = 16;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int TAP_W      = 4;
  localparam int STOP_W     = 2;
  localparam int IR_W       = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_TAP_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TAP_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_TO_TOGGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LED_HOLD_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_CLEAR_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_PERIOD   = 3'd5;

  localparam logic [CFG_W-1:0] RST_MAX_TAP_LENGTH = 16'd500;
  localparam logic [CFG_W-1:0] RST_MAX_TAP_PERIOD = 16'd1000;
  localparam logic [TAP_W-1:0] RST_TAPS_TO_TOGGLE = 4'd3;
  localparam logic [CFG_W-1:0] RST_LED_HOLD_TIME  = 16'd1000;
  localparam logic [CFG_W-1:0] RST_GAP_CLEAR_TIME = 16'd1500;
  localparam logic [CFG_W-1:0] RST_CALIB_PERIOD   = 16'd1000;

  localparam logic [TAP_W-1:0] TAP_FULL = 4'd15;

  localparam logic IN_CMD_TICK  = 1'b0;
  localparam logic IN_CMD_TOUCH = 1'b1;

  localparam logic [IR_W-1:0] IR_NONE     = 2'd0;
  localparam logic [IR_W-1:0] IR_PRESENCE = 2'd1;
  localparam logic [IR_W-1:0] IR_STOP     = 2'd2;

  localparam logic [STOP_W-1:0] STOP_IDLE = 2'd0;
  localparam logic [STOP_W-1:0] STOP_ONE  = 2'd1;
  localparam logic [STOP_W-1:0] STOP_DONE = 2'd2;

  typedef struct packed {
    logic            always_on;
    logic            mode_changed;
    logic            recalibrate;
    logic            ir_led_off;
    logic            red_led;
    logic [IR_W-1:0] ir_code;
  } out_item_t;

endpackage

[rtl/core/tap_gesture_beacon_control.sv]
// Tap-gesture beacon controller: timers, tap counting, mode toggle and IR stop sequence.
//
//  channel | direction | contents
//  in_     | slave     | tuser: cmd (tick or touch); tdata: left_touched, right_touched
//  out_    | master    | tdata: ir_code, red_led, ir_led_off, recalibrate, mode_changed,
//          |           |        always_on; tlast: last
//  cfg_    | slave     | index of the register and 16-bit write data
//
// Every request updates the state at the accepting edge.
// A touch request yields one or two results from a one-entry output register with a
// spare entry for the second result; a tick yields none.
// While a result waits, the input is refused if the output is stalled or the second
// result is still held, so after a request with two results the next waits for the first result to be taken.
// Reset is synchronous and active low; it restores the register defaults and clears state.
module tap_gesture_beacon_control #(
  parameter int TIMER_BITS = tgb_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Bit 0: left_touched, bit 1: right_touched, the rest zero.
  input  logic [tgb_pkg::IN_DATA_W-1:0]   in_tdata,
  // Bit 0: cmd.
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Bits 1:0 ir_code, 2 red_led, 3 ir_led_off, 4 recalibrate, 5 mode_changed,
  // 6 always_on, 7 zero.
  output logic [tgb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tgb_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CMP_W = (TIMER_BITS > tgb_pkg::CFG_W) ? TIMER_BITS : tgb_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic [tgb_pkg::CFG_W-1:0] max_len_r, max_period_r, led_hold_r, gap_clear_r, calib_per_r;
  logic [tgb_pkg::TAP_W-1:0] taps_tgl_r;

  logic [TIMER_BITS-1:0] press_r, since_r, calib_r, gap_r;
  logic [TIMER_BITS-1:0] press_nxt, since_nxt, calib_nxt, gap_nxt;
  logic                  pressed_r, pressed_nxt, mode_r, mode_nxt, led_r, led_nxt;
  logic [tgb_pkg::TAP_W-1:0]  tap_r, tap_nxt;
  logic [tgb_pkg::STOP_W-1:0] stop_r, stop_nxt;

  logic                 out_valid_r, out_last_r, pend_r;
  tgb_pkg::out_item_t   out_item_r, pend_item_r, item_nxt, second_nxt;
  logic                 last_nxt, two_nxt;

  logic in_fire, out_fire, left, right, recal, chg;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_tready = !out_valid_r || (out_tready && !pend_r);
  assign cfg_ready = 1'b1;
  assign left  = in_tdata[0];
  assign right = in_tdata[1];

  function automatic logic [CMP_W-1:0] tw(input logic [TIMER_BITS-1:0] v);
    tw = CMP_W'(v);
  endfunction

  function automatic logic [CMP_W-1:0] cw(input logic [tgb_pkg::CFG_W-1:0] v);
    cw = CMP_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= tgb_pkg::RST_MAX_TAP_LENGTH;
      max_period_r <= tgb_pkg::RST_MAX_TAP_PERIOD;
      taps_tgl_r   <= tgb_pkg::RST_TAPS_TO_TOGGLE;
      led_hold_r   <= tgb_pkg::RST_LED_HOLD_TIME;
      gap_clear_r  <= tgb_pkg::RST_GAP_CLEAR_TIME;
      calib_per_r  <= tgb_pkg::RST_CALIB_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tgb_pkg::REG_MAX_TAP_LENGTH: max_len_r    <= cfg_data;
        tgb_pkg::REG_MAX_TAP_PERIOD: max_period_r <= cfg_data;
        tgb_pkg::REG_TAPS_TO_TOGGLE: taps_tgl_r   <= cfg_data[tgb_pkg::TAP_W-1:0];
        tgb_pkg::REG_LED_HOLD_TIME:  led_hold_r   <= cfg_data;
        tgb_pkg::REG_GAP_CLEAR_TIME: gap_clear_r  <= cfg_data;
        tgb_pkg::REG_CALIB_PERIOD:   calib_per_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    press_nxt   = press_r;
    since_nxt   = since_r;
    calib_nxt   = calib_r;
    gap_nxt     = gap_r;
    pressed_nxt = pressed_r;
    tap_nxt     = tap_r;
    mode_nxt    = mode_r;
    led_nxt     = led_r;
    stop_nxt    = stop_r;
    recal       = 1'b0;
    chg         = 1'b0;
    item_nxt    = '0;
    second_nxt  = '0;
    last_nxt    = 1'b1;
    two_nxt     = 1'b0;

    if (in_tuser == tgb_pkg::IN_CMD_TICK) begin
      press_nxt = (press_r == TMAX) ? press_r : press_r + 1'b1;
      since_nxt = (since_r == TMAX) ? since_r : since_r + 1'b1;
      calib_nxt = (calib_r == TMAX) ? calib_r : calib_r + 1'b1;
    end else begin
      if (!left) begin
        if (right && !pressed_r) begin
          if (mode_r) begin
            led_nxt = 1'b0;
          end
          pressed_nxt = 1'b1;
          gap_nxt     = since_r;
          if (tw(since_r) > cw(gap_clear_r)) begin
            tap_nxt = '0;
          end
          press_nxt = '0;
          since_nxt = '0;
        end
        if (mode_r && right && pressed_nxt && tw(press_nxt) >= cw(led_hold_r)) begin
          led_nxt = 1'b1;
        end
        if (!right && pressed_r) begin
          pressed_nxt = 1'b0;
          if (tw(press_r) < cw(max_len_r) && tw(gap_r) < cw(max_period_r)
              && tap_r != tgb_pkg::TAP_FULL) begin
            tap_nxt = tap_r + 1'b1;
          end
          if (tap_nxt >= taps_tgl_r) begin
            mode_nxt = !mode_r;
            chg      = 1'b1;
          end
          if (mode_nxt) begin
            led_nxt = 1'b1;
          end
        end
      end

      if (!left && !right && tw(calib_r) >= cw(calib_per_r)) begin
        calib_nxt = '0;
        recal     = 1'b1;
      end

      item_nxt.ir_code = tgb_pkg::IR_PRESENCE;
      if (!mode_nxt) begin
        if (left || right) begin
          calib_nxt = '0;
          led_nxt   = 1'b1;
          stop_nxt  = tgb_pkg::STOP_IDLE;
        end else if (stop_r == tgb_pkg::STOP_IDLE) begin
          stop_nxt = tgb_pkg::STOP_ONE;
          last_nxt = 1'b0;
          two_nxt  = 1'b1;
        end else if (stop_r == tgb_pkg::STOP_ONE) begin
          stop_nxt            = tgb_pkg::STOP_DONE;
          led_nxt             = 1'b0;
          item_nxt.ir_code    = tgb_pkg::IR_STOP;
          item_nxt.ir_led_off = 1'b1;
        end else begin
          item_nxt.ir_code = tgb_pkg::IR_NONE;
        end
      end

      item_nxt.red_led      = led_nxt;
      item_nxt.recalibrate  = recal;
      item_nxt.mode_changed = chg;
      item_nxt.always_on    = mode_nxt;
      second_nxt.ir_code    = tgb_pkg::IR_PRESENCE;
      second_nxt.red_led    = led_nxt;
      second_nxt.always_on  = mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r   <= '0;
      since_r   <= '0;
      calib_r   <= '0;
      gap_r     <= '0;
      pressed_r <= 1'b0;
      tap_r     <= '0;
      mode_r    <= 1'b0;
      led_r     <= 1'b0;
      stop_r    <= tgb_pkg::STOP_IDLE;
    end else if (in_fire) begin
      press_r   <= press_nxt;
      since_r   <= since_nxt;
      calib_r   <= calib_nxt;
      gap_r     <= gap_nxt;
      pressed_r <= pressed_nxt;
      tap_r     <= tap_nxt;
      mode_r    <= mode_nxt;
      led_r     <= led_nxt;
      stop_r    <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (in_fire && in_tuser == tgb_pkg::IN_CMD_TOUCH) begin
      out_valid_r <= 1'b1;
      pend_r      <= two_nxt;
    end else if (out_fire) begin
      out_valid_r <= pend_r;
      pend_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tuser == tgb_pkg::IN_CMD_TOUCH) begin
      out_item_r  <= item_nxt;
      out_last_r  <= last_nxt;
      pend_item_r <= second_nxt;
    end else if (out_fire && pend_r) begin
      out_item_r <= pend_item_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_item_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_pend_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("second result held without a valid first result");

  a_stop_range: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r <= tgb_pkg::STOP_DONE)
    else $error("stop phase reached an unused value");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("first of two results not followed by the second");

  a_off_with_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[1:0] == tgb_pkg::IR_STOP)
    else $error("IR LED off without the stop code");
`endif

endmodule

[tb/sv/beacon_checker.sv]
// Checker for the tap controller: predicts every result from the observed requests and compares.
module beacon_checker #(
  parameter int TIMER_BITS = tgb_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // Bit 0: left_touched, bit 1: right_touched, the rest zero.
  input  logic [tgb_pkg::IN_DATA_W-1:0]  in_tdata,
  // Bit 0: cmd.
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // Bits 1:0 ir_code, 2 red_led, 3 ir_led_off, 4 recalibrate, 5 mode_changed,
  // 6 always_on, 7 zero.
  input  logic [tgb_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgb_pkg::CFG_W-1:0]      cfg_data,
  output int                             mismatch_count,
  output int                             awaited_count,
  output int                             results_checked
);

  typedef struct packed {
    tgb_pkg::out_item_t fields;
    logic               last;
  } beacon_result_t;

  beacon_result_t awaited_results[$];

  logic [tgb_pkg::CFG_W-1:0]  max_len, max_period, hold_time, clear_gap, calib_span;
  logic [tgb_pkg::TAP_W-1:0]  toggle_taps, taps;
  logic [TIMER_BITS-1:0]      press_t, since_t, calib_t, gap_t;
  logic                       pressed, always_on, led;
  logic [tgb_pkg::STOP_W-1:0] stop_phase;
  int                         errors = 0;
  int                         checked = 0;

  assign mismatch_count  = errors;
  assign results_checked = checked;

  function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] t);
    return (&t) ? t : t + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 100) begin
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  task automatic expect_result(input logic [tgb_pkg::IR_W-1:0] code, input logic off,
                               input logic recal, input logic chg, input logic fin);
    beacon_result_t r;
    r.fields.ir_code      = code;
    r.fields.red_led      = led;
    r.fields.ir_led_off   = off;
    r.fields.recalibrate  = recal;
    r.fields.mode_changed = chg;
    r.fields.always_on    = always_on;
    r.last                = fin;
    awaited_results.push_back(r);
  endtask

  task automatic clear_model();
    max_len     = tgb_pkg::RST_MAX_TAP_LENGTH;
    max_period  = tgb_pkg::RST_MAX_TAP_PERIOD;
    toggle_taps = tgb_pkg::RST_TAPS_TO_TOGGLE;
    hold_time   = tgb_pkg::RST_LED_HOLD_TIME;
    clear_gap   = tgb_pkg::RST_GAP_CLEAR_TIME;
    calib_span  = tgb_pkg::RST_CALIB_PERIOD;
    press_t     = '0;
    since_t     = '0;
    calib_t     = '0;
    gap_t       = '0;
    pressed     = 1'b0;
    taps        = '0;
    always_on   = 1'b0;
    stop_phase  = tgb_pkg::STOP_IDLE;
    led         = 1'b0;
    awaited_results.delete();
  endtask

  task automatic predict_event(input logic cmd, input logic l, input logic r);
    logic recal, chg;
    recal = 1'b0;
    chg   = 1'b0;
    if (cmd == tgb_pkg::IN_CMD_TICK) begin
      press_t = bump(press_t);
      since_t = bump(since_t);
      calib_t = bump(calib_t);
    end else begin
      if (!l) begin
        if (r && !pressed) begin
          if (always_on) led = 1'b0;
          pressed = 1'b1;
          gap_t   = since_t;
          if (gap_t > clear_gap) taps = '0;
          press_t = '0;
          since_t = '0;
        end
        if (always_on && r && pressed && press_t >= hold_time) led = 1'b1;
        if (!r && pressed) begin
          pressed = 1'b0;
          if (press_t < max_len && gap_t < max_period && taps < tgb_pkg::TAP_FULL)
            taps = taps + 1'b1;
          if (taps >= toggle_taps) begin
            always_on = ~always_on;
            chg       = 1'b1;
          end
          if (always_on) led = 1'b1;
        end
      end
      if (!l && !r && calib_t >= calib_span) begin
        calib_t = '0;
        recal   = 1'b1;
      end
      if (always_on) begin
        expect_result(tgb_pkg::IR_PRESENCE, 1'b0, recal, chg, 1'b1);
      end else if (l || r) begin
        calib_t    = '0;
        led        = 1'b1;
        stop_phase = tgb_pkg::STOP_IDLE;
        expect_result(tgb_pkg::IR_PRESENCE, 1'b0, recal, chg, 1'b1);
      end else if (stop_phase == tgb_pkg::STOP_IDLE) begin
        stop_phase = tgb_pkg::STOP_ONE;
        expect_result(tgb_pkg::IR_PRESENCE, 1'b0, recal, chg, 1'b0);
        expect_result(tgb_pkg::IR_PRESENCE, 1'b0, 1'b0, 1'b0, 1'b1);
      end else if (stop_phase == tgb_pkg::STOP_ONE) begin
        stop_phase = tgb_pkg::STOP_DONE;
        led        = 1'b0;
        expect_result(tgb_pkg::IR_STOP, 1'b1, recal, chg, 1'b1);
      end else begin
        expect_result(tgb_pkg::IR_NONE, 1'b0, recal, chg, 1'b1);
      end
    end
  endtask

  task automatic check_result();
    beacon_result_t     want;
    tgb_pkg::out_item_t got;
    got = out_tdata[$bits(tgb_pkg::out_item_t)-1:0];
    if (awaited_results.size() == 0) begin
      report_mismatch("result with nothing awaited, tdata", out_tdata, 0);
    end else begin
      want = awaited_results.pop_front();
      checked++;
      if (got.ir_code !== want.fields.ir_code)
        report_mismatch("ir_code", got.ir_code, want.fields.ir_code);
      if (got.red_led !== want.fields.red_led)
        report_mismatch("red_led", got.red_led, want.fields.red_led);
      if (got.ir_led_off !== want.fields.ir_led_off)
        report_mismatch("ir_led_off", got.ir_led_off, want.fields.ir_led_off);
      if (got.recalibrate !== want.fields.recalibrate)
        report_mismatch("recalibrate", got.recalibrate, want.fields.recalibrate);
      if (got.mode_changed !== want.fields.mode_changed)
        report_mismatch("mode_changed", got.mode_changed, want.fields.mode_changed);
      if (got.always_on !== want.fields.always_on)
        report_mismatch("always_on", got.always_on, want.fields.always_on);
      if (out_tlast !== want.last)
        report_mismatch("last", out_tlast, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tgb_pkg::REG_MAX_TAP_LENGTH: max_len     = cfg_data;
          tgb_pkg::REG_MAX_TAP_PERIOD: max_period  = cfg_data;
          tgb_pkg::REG_TAPS_TO_TOGGLE: toggle_taps = cfg_data[tgb_pkg::TAP_W-1:0];
          tgb_pkg::REG_LED_HOLD_TIME:  hold_time   = cfg_data;
          tgb_pkg::REG_GAP_CLEAR_TIME: clear_gap   = cfg_data;
          tgb_pkg::REG_CALIB_PERIOD:   calib_span  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_event(in_tuser, in_tdata[0], in_tdata[1]);
    end
    awaited_count <= awaited_results.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the tap controller testbench: clock, reset, stimulus phases and the final verdict.
module testbench;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tuser   = 1'b0;
  logic [tgb_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tready = 1'b0;
  logic                           cfg_valid  = 1'b0;
  logic [tgb_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [tgb_pkg::CFG_W-1:0]      cfg_data   = '0;
  logic                           calm       = 1'b0;
  wire                            in_tready, out_tvalid, out_tlast, cfg_ready;
  wire  [tgb_pkg::OUT_DATA_W-1:0] out_tdata;
  int                             mismatch_count, awaited_count, results_checked;
  int                             items_sent = 0;
  int                             reg_writes = 0;
  bit                             leftover   = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 25);

  tap_gesture_beacon_control uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  beacon_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .awaited_count(awaited_count),
    .results_checked(results_checked)
  );

  initial begin
    #(8 * 1_500_000);
    $display("Run did not finish within its time limit.");
    $display("FAIL");
    $finish;
  end

  function automatic logic coin();
    return $urandom_range(1) != 0;
  endfunction

  function automatic logic [tgb_pkg::CFG_W-1:0] pick(input int unsigned hi,
                                                     input int unsigned lo);
    int unsigned v;
    v = $urandom_range(hi, lo);
    return v[tgb_pkg::CFG_W-1:0];
  endfunction

  task automatic send_item(input logic cmd, input logic l, input logic r);
    while (!calm && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(tgb_pkg::IN_DATA_W-2){1'b0}}, r, l};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic ticks(input int n);
    repeat (n) send_item(tgb_pkg::IN_CMD_TICK, coin(), coin());
  endtask

  task automatic touch(input logic l, input logic r);
    send_item(tgb_pkg::IN_CMD_TOUCH, l, r);
  endtask

  task automatic write_reg(input logic [tgb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tgb_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_count != 0) leftover = 1'b1;
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [tgb_pkg::CFG_W-1:0] len,
                           input logic [tgb_pkg::CFG_W-1:0] period,
                           input logic [tgb_pkg::CFG_W-1:0] toggle,
                           input logic [tgb_pkg::CFG_W-1:0] hold,
                           input logic [tgb_pkg::CFG_W-1:0] gap,
                           input logic [tgb_pkg::CFG_W-1:0] calib);
    drain();
    write_reg(tgb_pkg::REG_MAX_TAP_LENGTH, len);
    write_reg(tgb_pkg::REG_MAX_TAP_PERIOD, period);
    write_reg(tgb_pkg::REG_TAPS_TO_TOGGLE, toggle);
    write_reg(tgb_pkg::REG_LED_HOLD_TIME, hold);
    write_reg(tgb_pkg::REG_GAP_CLEAR_TIME, gap);
    write_reg(tgb_pkg::REG_CALIB_PERIOD, calib);
  endtask

  task automatic gesture(input int span);
    int kind;
    kind = $urandom_range(99);
    if (kind < 55) begin
      touch(1'b0, 1'b1);
      ticks($urandom_range(span));
      if ($urandom_range(3) == 0) touch(1'b0, 1'b1);
      ticks($urandom_range(span));
      touch(1'b0, 1'b0);
      ticks($urandom_range(span));
    end else if (kind < 70) begin
      touch(1'b0, 1'b1);
      repeat ($urandom_range(4, 1)) begin
        ticks($urandom_range(span * 2));
        touch(1'b0, 1'b1);
      end
      touch(1'b0, 1'b0);
    end else if (kind < 85) begin
      touch(1'b1, coin());
      ticks($urandom_range(span));
      touch(coin(), coin());
      touch(1'b0, 1'b0);
    end else begin
      ticks($urandom_range(span * 3));
      send_item(coin(), coin(), coin());
    end
    repeat ($urandom_range(3)) touch(1'b0, 1'b0);
  endtask

  task automatic random_phase(input int target, input int span);
    int start;
    start = items_sent;
    while (items_sent - start < target) gesture(span);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: left pad skips tap tracking, the release and stop sequence,
    // then three quick taps switch to always-on mode.
    touch(1'b1, 1'b0);
    touch(1'b1, 1'b1);
    touch(1'b0, 1'b0);
    touch(1'b0, 1'b0);
    touch(1'b0, 1'b0);
    ticks(2);
    touch(1'b0, 1'b1);
    touch(1'b0, 1'b0);
    touch(1'b0, 1'b1);
    touch(1'b0, 1'b1);
    touch(1'b0, 1'b0);
    touch(1'b0, 1'b1);
    touch(1'b0, 1'b0);
    touch(1'b0, 1'b0);

    // A zero tap threshold toggles on every release; a held press lights the LED.
    configure(16'd4, 16'd12, 16'd0, 16'd2, 16'd16, 16'd6);
    touch(1'b0, 1'b1);
    ticks(3);
    touch(1'b0, 1'b1);
    touch(1'b0, 1'b0);
    touch(1'b0, 1'b1);
    touch(1'b0, 1'b0);
    ticks(7);
    touch(1'b0, 1'b0);

    configure(16'd6, 16'd20, 16'd3, 16'd5, 16'd24, 16'd12);
    random_phase(220, 8);
    configure(16'hFFFF, 16'hFFFF, 16'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    calm <= 1'b1;
    random_phase(200, 10);
    calm <= 1'b0;
    configure(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    random_phase(150, 3);
    configure(16'd3, 16'd8, 16'd2, 16'd1, 16'd10, 16'd4);
    random_phase(200, 5);
    configure(16'd2, 16'hFFFF, 16'd15, 16'd0, 16'hFFFF, 16'd1);
    random_phase(200, 4);
    repeat (2) begin
      configure(pick(12, 1), pick(30, 4), pick(6, 1), pick(10, 0), pick(30, 0), pick(20, 0));
      random_phase(200, 10);
    end

    // A long idle stretch with steady handshakes ends in a recalibration request.
    configure(16'd4, 16'd8, 16'd15, 16'hFFFF, 16'hFFFF, 16'd20);
    calm <= 1'b1;
    ticks(30);
    touch(1'b0, 1'b0);
    touch(1'b0, 1'b1);
    touch(1'b0, 1'b0);
    touch(1'b0, 1'b0);
    calm <= 1'b0;

    drain();
    $display("Sent %0d requests and checked %0d results across %0d register writes.",
             items_sent, results_checked, reg_writes);
    $display("Thresholds ranged from zero to full scale, with tap-count saturation.");
    if (leftover) $display("Some predicted results never arrived.");
    if (mismatch_count == 0 && !leftover) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
